### rtl/tdf_pkg.sv
package tdf_pkg;

	// field widths of the ports
	localparam int VALUE_W = 32;
	localparam int PRIME_W = 32;
	localparam int EXP_W   = 6;

	// defaults and fixed constants of the algorithm
	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_RESULTS    = 9;
	localparam int FIRST_DIVISOR  = 2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT
	} state_t;

endpackage

### rtl/tdf_divider.sv
// Radix-2 restoring divider: one quotient bit per cycle.
module tdf_divider #(
	parameter int W = tdf_pkg::VALUE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     prem_q;
	logic [W-1:0]     dvs_q;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       fits;

	// one shift-subtract step
	always_comb begin
		trial = {prem_q, quo_q[W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = ~diff[W];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath: dividend shifts out, quotient bits shift in
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q  <= dividend;
			prem_q <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quo_q  <= {quo_q[W-2:0], fits};
			prem_q <= fits ? diff[W-1:0] : trial[W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = prem_q;

endmodule

### rtl/trial_division_factorizer_top.sv
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+-----------------------------------
// command   | value                          | taken when start && !busy
// result    | prime, exponent, last          | one-cycle strobe per result
//
// Each trial divisor, and each repeat of a divisor that divides, costs one division
// on the serial divider. A 32-bit prime near 2^32 needs about 65536 trials.
// An input below two is answered in the cycle after it is taken. busy is high
// while an input is being worked; results cannot be stalled. Reset returns the
// sequencer to idle.
module trial_division_factorizer_top #(
	parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [tdf_pkg::VALUE_W-1:0]  value,
	output logic                         strobe,
	output logic [tdf_pkg::PRIME_W-1:0]  prime,
	output logic [tdf_pkg::EXP_W-1:0]    exponent,
	output logic                         last
);

	// datapath width: only the low VALUE_BITS bits of value count
	localparam int RW    = (VALUE_BITS < tdf_pkg::VALUE_W) ? VALUE_BITS : tdf_pkg::VALUE_W;
	localparam int CNT_W = $clog2(tdf_pkg::MAX_RESULTS);

	tdf_pkg::state_t state_q, state_d;

	logic [RW-1:0]               rem_q;
	logic [RW-1:0]               dvs_q;
	logic [tdf_pkg::EXP_W-1:0]   e_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        strobe_q;
	logic [tdf_pkg::PRIME_W-1:0] prime_q;
	logic [tdf_pkg::EXP_W-1:0]   exp_q;
	logic                        last_q;

	logic          accept;
	logic          tiny;
	logic          div_go;
	logic          div_done;
	logic [RW-1:0] div_quo;
	logic [RW-1:0] div_rem;
	logic [RW-1:0] value_m;

	// outcome of one division
	logic in_run;
	logic rem_zero;
	logic past_root;
	logic cap;
	logic finish;

	assign value_m = value[RW-1:0];
	assign accept  = start && !busy;
	assign tiny    = (value_m < RW'(tdf_pkg::FIRST_DIVISOR));

	always_comb begin
		in_run    = (e_q != '0);
		rem_zero  = (div_rem == '0);
		past_root = (dvs_q > div_quo);
		cap       = (cnt_q == CNT_W'(tdf_pkg::MAX_RESULTS - 1));
		if (in_run)
			finish = !rem_zero && ((rem_q == RW'(1)) || cap);
		else
			finish = past_root;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tdf_pkg::ST_IDLE: begin
				if (accept && !tiny)
					state_d = tdf_pkg::ST_ISSUE;
			end
			tdf_pkg::ST_ISSUE: state_d = tdf_pkg::ST_WAIT;
			tdf_pkg::ST_WAIT: begin
				if (div_done)
					state_d = finish ? tdf_pkg::ST_IDLE : tdf_pkg::ST_ISSUE;
			end
			default: state_d = tdf_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy   = 1'b1;
		div_go = 1'b0;
		case (state_q)
			tdf_pkg::ST_IDLE:  busy   = 1'b0;
			tdf_pkg::ST_ISSUE: div_go = 1'b1;
			tdf_pkg::ST_WAIT:  busy   = 1'b1;
			default:           busy   = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tdf_pkg::ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			if (state_q == tdf_pkg::ST_IDLE && accept && tiny)
				strobe_q <= 1'b1;
			else if (state_q == tdf_pkg::ST_WAIT && div_done) begin
				if (in_run ? !rem_zero : past_root)
					strobe_q <= 1'b1;
			end
		end
	end

	// working registers and result register
	always_ff @(posedge clk) begin
		if (state_q == tdf_pkg::ST_IDLE && accept) begin
			rem_q <= value_m;
			dvs_q <= RW'(tdf_pkg::FIRST_DIVISOR);
			e_q   <= '0;
			cnt_q <= '0;
			if (tiny) begin
				prime_q <= '0;
				exp_q   <= '0;
				last_q  <= 1'b1;
			end
		end else if (state_q == tdf_pkg::ST_WAIT && div_done) begin
			if (in_run) begin
				if (rem_zero) begin
					// divisor goes again
					rem_q <= div_quo;
					e_q   <= e_q + 1'b1;
				end else begin
					// run of this divisor ends: report it
					prime_q <= tdf_pkg::PRIME_W'(dvs_q);
					exp_q   <= e_q;
					last_q  <= finish;
					cnt_q   <= cnt_q + 1'b1;
					e_q     <= '0;
					dvs_q   <= dvs_q + 1'b1;
				end
			end else if (past_root) begin
				// divisor squared exceeds remainder: remainder is prime
				prime_q <= tdf_pkg::PRIME_W'(rem_q);
				exp_q   <= tdf_pkg::EXP_W'(1);
				last_q  <= 1'b1;
				cnt_q   <= cnt_q + 1'b1;
				rem_q   <= RW'(1);
			end else if (rem_zero) begin
				rem_q <= div_quo;
				e_q   <= tdf_pkg::EXP_W'(1);
			end else begin
				dvs_q <= dvs_q + 1'b1;
			end
		end
	end

	tdf_divider #(
		.W (RW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (rem_q),
		.divisor   (dvs_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign strobe   = strobe_q;
	assign prime    = prime_q;
	assign exponent = exp_q;
	assign last     = last_q;

endmodule

### tb/tdf_factor_check.sv
`timescale 1ns / 1ps

// Watches the command and result channels, predicts the factor list of every
// accepted command and compares each result transaction against it.
module tdf_factor_check #(
	parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [tdf_pkg::VALUE_W-1:0] value,
	input  logic                        strobe,
	input  logic [tdf_pkg::PRIME_W-1:0] prime,
	input  logic [tdf_pkg::EXP_W-1:0]   exponent,
	input  logic                        last,
	output int                          fail_count,
	output int                          pending
);

	typedef struct packed {
		logic [tdf_pkg::PRIME_W-1:0] prime;
		logic [tdf_pkg::EXP_W-1:0]   exponent;
		logic                        last;
	} factor_t;

	localparam longint unsigned EXP_MAX = (64'd1 << tdf_pkg::EXP_W) - 64'd1;

	factor_t expected_factors[$];
	int      errs = 0;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// trial division; one entry per distinct prime, a zero entry below two
	function automatic void predict_factors(input logic [tdf_pkg::VALUE_W-1:0] raw);
		longint unsigned rem, div, mult, mask;
		factor_t         found[tdf_pkg::MAX_RESULTS];
		int              n;
		mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
		rem  = {32'd0, raw} & mask;
		n    = 0;
		if (rem < 2) begin
			found[0] = '{prime: '0, exponent: '0, last: 1'b1};
			expected_factors = {expected_factors, found[0]};
			return;
		end
		div = tdf_pkg::FIRST_DIVISOR;
		while (rem > 1 && n < tdf_pkg::MAX_RESULTS) begin
			if (div > rem / div) begin
				// nothing left below the square root: remainder is prime
				found[n] = '{prime: rem[tdf_pkg::PRIME_W-1:0], exponent: 1, last: 1'b0};
				n++;
				rem = 1;
			end else begin
				if (rem % div == 0) begin
					mult = 0;
					while (rem % div == 0) begin
						rem = rem / div;
						mult++;
					end
					if (mult > EXP_MAX)
						mult = EXP_MAX;
					found[n] = '{prime: div[tdf_pkg::PRIME_W-1:0],
						exponent: mult[tdf_pkg::EXP_W-1:0], last: 1'b0};
					n++;
				end
				div++;
			end
		end
		for (int i = 0; i < n; i++) begin
			found[i].last = (i == n - 1);
			expected_factors = {expected_factors, found[i]};
		end
	endfunction

	// sample both channels at the edge that accepts them
	always @(posedge clk) begin
		factor_t want;
		if (arst_n) begin
			if (start && !busy)
				predict_factors(value);
			if (strobe) begin
				if (expected_factors.size() == 0) begin
					$error("result with nothing expected: prime %0d exponent %0d last %0b",
						prime, exponent, last);
					errs++;
				end else begin
					want = expected_factors.pop_front();
					if (prime !== want.prime) begin
						$error("prime: expected %0d, got %0d", want.prime, prime);
						errs++;
					end
					if (exponent !== want.exponent) begin
						$error("exponent: expected %0d, got %0d", want.exponent, exponent);
						errs++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						errs++;
					end
				end
			end
		end
		fail_count <= errs;
		pending    <= expected_factors.size();
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int STALL_LIMIT  = 200000;
	localparam int SETTLE_TICKS = 100;
	localparam int RANDOM_ITEMS = 100;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [tdf_pkg::VALUE_W-1:0] value;
	logic                        strobe;
	logic [tdf_pkg::PRIME_W-1:0] prime;
	logic [tdf_pkg::EXP_W-1:0]   exponent;
	logic                        last;
	int                          fail_count;
	int                          pending;
	int                          quiet_cycles = 0;

	trial_division_factorizer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.value   (value),
		.strobe  (strobe),
		.prime   (prime),
		.exponent(exponent),
		.last    (last)
	);

	tdf_factor_check factor_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.prime     (prime),
		.exponent  (exponent),
		.last      (last),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// 100 MHz clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// random idle cycles ahead of a command, junk on value while start is low
	task automatic maybe_idle(input bit no_gaps);
		if (!no_gaps) begin
			while ($urandom_range(99) < 17) begin
				start <= 1'b0;
				value <= $urandom;
				@(posedge clk);
			end
		end
	endtask

	// present one command and hold it until the block takes it
	task automatic send_value(input logic [tdf_pkg::VALUE_W-1:0] v);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	// stop sending until every predicted factor has come back
	task automatic drain_factors();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// mostly products of small factors with a modest cofactor, so trial
	// division stays short; some raw small values and some below two
	function automatic logic [tdf_pkg::VALUE_W-1:0] pick_value();
		logic [63:0] v;
		int          sel;
		int          k;
		int          s;
		sel = $urandom_range(99);
		if (sel < 5)
			return $urandom_range(1, 0);
		if (sel < 15)
			return $urandom_range(262143, 2);
		v = $urandom_range(65535, 1);
		repeat ($urandom_range(5, 0)) begin
			k = $urandom_range(60, 2);
			if (v * k < 64'h1_0000_0000)
				v = v * k;
		end
		s = $urandom_range(31, 0);
		if ((v << s) < 64'h1_0000_0000)
			v = v << s;
		return v[tdf_pkg::VALUE_W-1:0];
	endfunction

	initial begin
		logic [tdf_pkg::VALUE_W-1:0] directed[$];
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero, one, smallest primes, all ones, high power of two, nine
		// distinct primes, large exponents, prime squared, prime inputs,
		// composites ending in a prime above the square-root bound
		directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12,
			32'hFFFF_FFFF, 32'h8000_0000, 32'd223092870, 32'd3486784401,
			32'd63001, 32'd65521, 32'd65537, 32'd131042, 32'hAAAA_AAAA,
			32'h5555_5555, 32'd4294836225, 32'hC000_0000, 32'd1048573};
		foreach (directed[i]) begin
			maybe_idle(1'b0);
			send_value(directed[i]);
		end
		drain_factors();

		// random commands; a middle stretch runs back to back
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 70)
				drain_factors();
			maybe_idle(i >= 30 && i < 60);
			send_value(pick_value());
		end

		drain_factors();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
